[rtl/sfr_pkg.sv]
// sfr_pkg: shared types and constants of the serial frame receiver.
// No dependencies; imported by sfr_front, sfr_cmd_fifo, sfr_back and serial_frame_receiver.
package sfr_pkg;

    localparam int MAX_FRAME_DEF = 64;
    localparam int LEN_W         = 7;
    localparam int CNT_W         = 16;
    localparam int CFG_W         = 16;
    localparam int CMD_DEPTH     = 2;

    localparam logic [7:0] FILLER_BYTE = 8'hAA;

    localparam logic [7:0]  START_RST   = 8'd16;
    localparam logic [7:0]  END_RST     = 8'd3;
    localparam logic [15:0] TIMEOUT_RST = 16'd100;

    typedef enum logic [1:0] {
        ST_PAYLOAD = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_CKSUM   = 2'd2,
        ST_OVF     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CFG_START   = 2'd0,
        CFG_END     = 2'd1,
        CFG_TIMEOUT = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0]  start_byte;
        logic [7:0]  end_byte;
        logic [15:0] timeout_ticks;
    } cfg_t;

    // One entry of the front-to-back queue: a payload run or a single status beat.
    typedef struct packed {
        status_t            status;
        logic [LEN_W-1:0]   len;
        logic [CNT_W-1:0]   frames;
        logic [CNT_W-1:0]   errors;
        logic [CNT_W-1:0]   lost;
    } cmd_t;

endpackage

[rtl/sfr_if.sv]
// sfr_in_if / sfr_out_if: valid-ready channels of the serial frame receiver.
// Depends on nothing but the field widths of the block.
interface sfr_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] rx_byte;

    modport source (output valid, output kind, output rx_byte, input ready);
    modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

interface sfr_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data;
    logic        last;
    logic [1:0]  status;
    logic [6:0]  frame_length;
    logic [15:0] frames_seen;
    logic [15:0] errors_seen;
    logic [15:0] lost_seen;

    modport source (output valid, output data, output last, output status,
                    output frame_length, output frames_seen, output errors_seen,
                    output lost_seen, input ready);
    modport sink   (input valid, input data, input last, input status,
                    input frame_length, input frames_seen, input errors_seen,
                    input lost_seen, output ready);
endinterface

[rtl/sfr_ram.sv]
// sfr_ram: generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module sfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

[rtl/sfr_front.sv]
// sfr_front: byte/tick parser of the serial frame receiver; fills the payload
// buffer and queues one command per checked or overflowed frame. Uses sfr_pkg.
module sfr_front #(
    parameter int MAX_FRAME = sfr_pkg::MAX_FRAME_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sfr_pkg::cfg_t                cfg,
    input  logic                         item_valid,
    input  logic                         item_kind,
    input  logic [7:0]                   item_byte,
    output logic                         item_ready,
    input  logic                         run_done,
    input  logic                         queue_full,
    output logic                         push,
    output sfr_pkg::cmd_t                push_cmd,
    output logic                         wr_en,
    output logic [$clog2(MAX_FRAME)-1:0] wr_addr,
    output logic [7:0]                   wr_data
);
    import sfr_pkg::*;

    localparam int AW   = $clog2(MAX_FRAME);
    localparam int WI_W = $clog2(MAX_FRAME + 1);

    typedef enum logic [2:0] {PH_IDLE, PH_OPEN1, PH_BODY, PH_ESC, PH_CHECK} phase_t;

    phase_t            phase_reg, phase_next;
    logic [7:0]        xor_reg, xor_next;
    logic [7:0]        bc_reg, bc_next;
    logic [WI_W-1:0]   wi_reg, wi_next;
    logic [15:0]       timer_reg, timer_next;
    logic [CNT_W-1:0]  frames_reg, frames_next;
    logic [CNT_W-1:0]  errors_reg, errors_next;
    logic [CNT_W-1:0]  lost_reg, lost_next;
    logic              busy_reg, busy_next;
    logic              pend_reg, pend_next;
    logic [AW-1:0]     pend_addr_reg, pend_addr_next;
    logic [7:0]        pend_data_reg, pend_data_next;
    logic              accept;
    status_t           push_status;

    // Input stalls while the buffer is being read out, the second byte of an
    // escaped pair is still to be written, or the command queue is full.
    assign item_ready = !busy_reg && !pend_reg && !queue_full;
    assign accept     = item_valid && item_ready;

    always_comb
    begin
        phase_next     = phase_reg;
        xor_next       = xor_reg;
        bc_next        = bc_reg;
        wi_next        = wi_reg;
        timer_next     = timer_reg;
        frames_next    = frames_reg;
        errors_next    = errors_reg;
        lost_next      = lost_reg;
        busy_next      = busy_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        pend_data_next = pend_data_reg;
        push           = 1'b0;
        push_status    = ST_PAYLOAD;
        wr_en          = 1'b0;
        wr_addr        = wi_reg[AW-1:0];
        wr_data        = item_byte;

        if (run_done)
        begin
            busy_next = 1'b0;
        end

        if (pend_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = pend_addr_reg;
            wr_data = pend_data_reg;
        end

        if (accept)
        begin
            if (item_kind)
            begin
                if (timer_reg >= cfg.timeout_ticks)
                begin
                    phase_next = PH_IDLE;
                end
                else
                begin
                    timer_next = timer_reg + 16'd1;
                end
            end
            else
            begin
                timer_next = '0;
                bc_next    = bc_reg + 8'd1;
                unique case (phase_reg)
                    PH_IDLE:
                    begin
                        if (item_byte == cfg.start_byte)
                        begin
                            phase_next = PH_OPEN1;
                        end
                        else if (item_byte != FILLER_BYTE)
                        begin
                            lost_next = lost_reg + CNT_W'(1);
                        end
                    end
                    PH_OPEN1:
                    begin
                        if (item_byte == cfg.start_byte)
                        begin
                            phase_next = PH_BODY;
                            xor_next   = '0;
                            wi_next    = '0;
                            bc_next    = 8'd2;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_BODY:
                    begin
                        xor_next = xor_reg ^ item_byte;
                        if (item_byte == cfg.start_byte)
                        begin
                            phase_next = PH_ESC;
                        end
                        else if (wi_reg == WI_W'(MAX_FRAME))
                        begin
                            phase_next  = PH_IDLE;
                            errors_next = errors_reg + CNT_W'(1);
                            push        = 1'b1;
                            push_status = ST_OVF;
                        end
                        else
                        begin
                            wr_en   = 1'b1;
                            wr_data = item_byte;
                            wi_next = wi_reg + WI_W'(1);
                        end
                    end
                    PH_ESC:
                    begin
                        xor_next = xor_reg ^ item_byte;
                        if (item_byte == cfg.end_byte)
                        begin
                            phase_next = PH_CHECK;
                        end
                        else if (wi_reg >= WI_W'(MAX_FRAME - 1))
                        begin
                            phase_next  = PH_IDLE;
                            errors_next = errors_reg + CNT_W'(1);
                            push        = 1'b1;
                            push_status = ST_OVF;
                        end
                        else
                        begin
                            // literal start byte now, the escaped byte next cycle
                            wr_en          = 1'b1;
                            wr_data        = cfg.start_byte;
                            pend_next      = 1'b1;
                            pend_addr_next = wi_reg[AW-1:0] + AW'(1);
                            pend_data_next = item_byte;
                            wi_next        = wi_reg + WI_W'(2);
                            phase_next     = PH_BODY;
                        end
                    end
                    PH_CHECK:
                    begin
                        frames_next = frames_reg + CNT_W'(1);
                        phase_next  = PH_IDLE;
                        push        = 1'b1;
                        if ((xor_reg ^ bc_next) == item_byte)
                        begin
                            if (wi_reg == '0)
                            begin
                                push_status = ST_EMPTY;
                            end
                            else
                            begin
                                push_status = ST_PAYLOAD;
                                busy_next   = 1'b1;
                            end
                        end
                        else
                        begin
                            errors_next = errors_reg + CNT_W'(1);
                            push_status = ST_CKSUM;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end

        push_cmd.status = push_status;
        push_cmd.len    = (push_status == ST_EMPTY) ? '0 : LEN_W'(wi_reg);
        push_cmd.frames = frames_next;
        push_cmd.errors = errors_next;
        push_cmd.lost   = lost_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            xor_reg       <= '0;
            bc_reg        <= '0;
            wi_reg        <= '0;
            timer_reg     <= '0;
            frames_reg    <= '0;
            errors_reg    <= '0;
            lost_reg      <= '0;
            busy_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            pend_addr_reg <= '0;
            pend_data_reg <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            xor_reg       <= xor_next;
            bc_reg        <= bc_next;
            wi_reg        <= wi_next;
            timer_reg     <= timer_next;
            frames_reg    <= frames_next;
            errors_reg    <= errors_next;
            lost_reg      <= lost_next;
            busy_reg      <= busy_next;
            pend_reg      <= pend_next;
            pend_addr_reg <= pend_addr_next;
            pend_data_reg <= pend_data_next;
        end
    end
endmodule

[rtl/sfr_cmd_fifo.sv]
// sfr_cmd_fifo: short command queue between front and back.
// Uses sfr_pkg (cmd_t, CMD_DEPTH).
module sfr_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sfr_pkg::cmd_t push_cmd,
    input  logic          pop,
    output sfr_pkg::cmd_t head,
    output logic          empty,
    output logic          full
);
    import sfr_pkg::*;

    localparam int PW = $clog2(CMD_DEPTH);
    localparam int CW = $clog2(CMD_DEPTH + 1);

    cmd_t          entry_reg [CMD_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CW'(CMD_DEPTH));
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(CMD_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(CMD_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end
endmodule

[rtl/sfr_back.sv]
// sfr_back: drains queued commands into result beats, reading payload runs
// from the frame buffer. Uses sfr_pkg.
module sfr_back #(
    parameter int MAX_FRAME = sfr_pkg::MAX_FRAME_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sfr_pkg::cmd_t                head,
    input  logic                         empty,
    output logic                         pop,
    output logic                         run_done,
    output logic                         rd_en,
    output logic [$clog2(MAX_FRAME)-1:0] rd_addr,
    input  logic [7:0]                   rd_data,
    sfr_out_if.source                    result
);
    import sfr_pkg::*;

    localparam int AW = $clog2(MAX_FRAME);

    typedef enum logic [1:0] {B_IDLE, B_READ, B_LOAD} bstate_t;

    bstate_t           state_reg;
    cmd_t              cmd_reg;
    logic [AW-1:0]     idx_reg;
    logic              valid_reg;
    logic [7:0]        data_reg;
    logic              last_reg;
    status_t           status_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [CNT_W-1:0]  frames_reg;
    logic [CNT_W-1:0]  errors_reg;
    logic [CNT_W-1:0]  lost_reg;
    logic              out_free;
    logic              is_last;
    logic              load_beat;

    assign out_free = !valid_reg || result.ready;
    assign pop      = (state_reg == B_IDLE) && !empty
                      && ((head.status == ST_PAYLOAD) || out_free);
    assign rd_en    = (state_reg == B_READ);
    assign rd_addr  = idx_reg;
    assign is_last  = (LEN_W'(idx_reg) + LEN_W'(1)) == cmd_reg.len;
    // buffer is released once its final byte has left the read port
    assign run_done = (state_reg == B_LOAD) && out_free && is_last;
    // output register takes a new beat this cycle
    assign load_beat = ((state_reg == B_IDLE) && pop && (head.status != ST_PAYLOAD))
                       || ((state_reg == B_LOAD) && out_free);

    assign result.valid        = valid_reg;
    assign result.data         = data_reg;
    assign result.last         = last_reg;
    assign result.status       = status_reg;
    assign result.frame_length = len_reg;
    assign result.frames_seen  = frames_reg;
    assign result.errors_seen  = errors_reg;
    assign result.lost_seen    = lost_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            cmd_reg    <= '0;
            idx_reg    <= '0;
            valid_reg  <= 1'b0;
            data_reg   <= '0;
            last_reg   <= 1'b0;
            status_reg <= ST_PAYLOAD;
            len_reg    <= '0;
            frames_reg <= '0;
            errors_reg <= '0;
            lost_reg   <= '0;
        end
        else
        begin
            if (load_beat)
            begin
                valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                valid_reg <= 1'b0;
            end
            unique case (state_reg)
                B_IDLE:
                begin
                    if (pop)
                    begin
                        if (head.status == ST_PAYLOAD)
                        begin
                            cmd_reg   <= head;
                            idx_reg   <= '0;
                            state_reg <= B_READ;
                        end
                        else
                        begin
                            data_reg   <= '0;
                            last_reg   <= 1'b1;
                            status_reg <= head.status;
                            len_reg    <= head.len;
                            frames_reg <= head.frames;
                            errors_reg <= head.errors;
                            lost_reg   <= head.lost;
                        end
                    end
                end
                B_READ:
                begin
                    state_reg <= B_LOAD;
                end
                B_LOAD:
                begin
                    if (out_free)
                    begin
                        data_reg   <= rd_data;
                        last_reg   <= is_last;
                        status_reg <= ST_PAYLOAD;
                        len_reg    <= cmd_reg.len;
                        frames_reg <= cmd_reg.frames;
                        errors_reg <= cmd_reg.errors;
                        lost_reg   <= cmd_reg.lost;
                        if (is_last)
                        begin
                            state_reg <= B_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + AW'(1);
                            state_reg <= B_READ;
                        end
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end
endmodule

[rtl/serial_frame_receiver.sv]
// serial_frame_receiver: recovers start-byte framed messages from a stream of
// received bytes and idle ticks. A byte or tick is taken every cycle while the
// parser is free; an escaped literal pair holds off input while its second
// buffer write is done. A good frame of N payload bytes holds off input after
// its checksum beat, and through any result-side stalls, while the run
// is read out of the frame buffer (read, then load the output register, per
// beat). Status beats (empty frame, checksum error, overflow) go through a
// two-entry queue and hold off input only while that queue is full.
// Depends on sfr_pkg, sfr_if, sfr_ram, sfr_front, sfr_cmd_fifo and sfr_back.
module serial_frame_receiver #(
    parameter int MAX_FRAME = sfr_pkg::MAX_FRAME_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    sfr_in_if.sink                    item,
    sfr_out_if.source                 result,
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_index,
    input  logic [sfr_pkg::CFG_W-1:0] cfg_data
);
    import sfr_pkg::*;

    localparam int AW = $clog2(MAX_FRAME);

    cfg_t           cfg_reg;
    logic           push;
    cmd_t           push_cmd;
    logic           pop;
    cmd_t           head;
    logic           empty;
    logic           full;
    logic           run_done;
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic [7:0]     wr_data;
    logic           rd_en;
    logic [AW-1:0]  rd_addr;
    logic [7:0]     rd_data;
    logic           front_ready;

    assign item.ready = front_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_byte    <= START_RST;
            cfg_reg.end_byte      <= END_RST;
            cfg_reg.timeout_ticks <= TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_START:   cfg_reg.start_byte    <= cfg_data[7:0];
                CFG_END:     cfg_reg.end_byte      <= cfg_data[7:0];
                CFG_TIMEOUT: cfg_reg.timeout_ticks <= cfg_data[15:0];
                default:     cfg_reg               <= cfg_reg;
            endcase
        end
    end

    sfr_front #(.MAX_FRAME(MAX_FRAME)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (item.valid),
        .item_kind  (item.kind),
        .item_byte  (item.rx_byte),
        .item_ready (front_ready),
        .run_done   (run_done),
        .queue_full (full),
        .push       (push),
        .push_cmd   (push_cmd),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data)
    );

    sfr_ram #(.WIDTH(8), .DEPTH(MAX_FRAME)) u_buf (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    sfr_cmd_fifo u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .empty    (empty),
        .full     (full)
    );

    sfr_back #(.MAX_FRAME(MAX_FRAME)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .run_done (run_done),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .result   (result)
    );
endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// tb: self-checking bench for serial_frame_receiver; frame parser prediction in a scoreboard class.
// Depends on rtl/sfr_pkg.sv, rtl/sfr_if.sv and the serial_frame_receiver RTL.
module tb;
    import sfr_pkg::*;

    localparam int MAX_FRAME     = MAX_FRAME_DEF;
    localparam int GAP_PCT       = 16;
    localparam int SETTLE_CYCLES = 200;
    localparam int STALL_LIMIT   = 4000;
    localparam int REPORT_LIMIT  = 10;

    localparam logic       KIND_BYTE = 1'b0;
    localparam logic       KIND_TICK = 1'b1;
    localparam logic [1:0] CFG_SPARE = 2'd3;   // unmapped index, must be ignored

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_OPEN1 = 3'd1,
        PH_BODY  = 3'd2,
        PH_ESC   = 3'd3,
        PH_CHECK = 3'd4
    } parse_phase_t;

    typedef enum int {
        EXTRA_NONE,
        EXTRA_OVERFLOW,
        EXTRA_EDGE_OVERFLOW,
        EXTRA_FULL_FRAME
    } extra_t;

    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        status_t     status;
        logic [6:0]  frame_length;
        logic [15:0] frames;
        logic [15:0] errors;
        logic [15:0] lost;
    } frame_beat_t;

    typedef logic [7:0] octet_q_t [$];

    class frame_scoreboard;
        logic [7:0]   start_code;
        logic [7:0]   end_code;
        logic [15:0]  timeout_limit;
        parse_phase_t phase;
        logic [7:0]   xor_acc;
        logic [7:0]   byte_cnt;
        logic [7:0]   payload [MAX_FRAME];
        logic [6:0]   wr_idx;
        logic [15:0]  idle_ticks;
        logic [15:0]  frame_cnt;
        logic [15:0]  error_cnt;
        logic [15:0]  lost_cnt;
        frame_beat_t  expected_beats [$];
        int           mismatches;
        int           checked;

        function new();
            start_code    = START_RST;
            end_code      = END_RST;
            timeout_limit = TIMEOUT_RST;
            phase         = PH_IDLE;
            xor_acc       = '0;
            byte_cnt      = '0;
            wr_idx        = '0;
            idle_ticks    = '0;
            frame_cnt     = '0;
            error_cnt     = '0;
            lost_cnt      = '0;
            mismatches    = 0;
            checked       = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] value);
            if (idx == CFG_START)
                start_code = value[7:0];
            else if (idx == CFG_END)
                end_code = value[7:0];
            else if (idx == CFG_TIMEOUT)
                timeout_limit = value;
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction

        function void push_beat(logic [7:0] d, logic l, status_t s, logic [6:0] len);
            frame_beat_t b;
            b.data         = d;
            b.last         = l;
            b.status       = s;
            b.frame_length = len;
            b.frames       = frame_cnt;
            b.errors       = error_cnt;
            b.lost         = lost_cnt;
            expected_beats.push_back(b);
        endfunction

        function void drop_frame();
            error_cnt++;
            phase = PH_IDLE;
            push_beat(8'h00, 1'b1, ST_OVF, wr_idx);
        endfunction

        function void parse_beat(logic kind, logic [7:0] b);
            int i;
            if (kind == KIND_TICK) begin
                if (idle_ticks >= timeout_limit)
                    phase = PH_IDLE;
                else
                    idle_ticks++;
                return;
            end
            idle_ticks = '0;
            byte_cnt++;
            case (phase)
                PH_IDLE:
                begin
                    if (b == start_code)
                        phase = PH_OPEN1;
                    else if (b != FILLER_BYTE)
                        lost_cnt++;
                end
                PH_OPEN1:
                begin
                    if (b == start_code) begin
                        phase    = PH_BODY;
                        xor_acc  = '0;
                        wr_idx   = '0;
                        byte_cnt = 8'd2;
                    end else begin
                        phase = PH_IDLE;
                    end
                end
                PH_BODY:
                begin
                    xor_acc ^= b;
                    if (b == start_code)
                        phase = PH_ESC;
                    else if (int'(wr_idx) + 1 > MAX_FRAME)
                        drop_frame();
                    else begin
                        payload[wr_idx] = b;
                        wr_idx++;
                    end
                end
                PH_ESC:
                begin
                    xor_acc ^= b;
                    if (b == end_code)
                        phase = PH_CHECK;
                    else if (int'(wr_idx) + 2 > MAX_FRAME)
                        drop_frame();
                    else begin
                        payload[wr_idx]     = start_code;
                        payload[wr_idx + 1] = b;
                        wr_idx += 2;
                        phase = PH_BODY;
                    end
                end
                PH_CHECK:
                begin
                    frame_cnt++;
                    phase = PH_IDLE;
                    if ((xor_acc ^ byte_cnt) == b) begin
                        if (wr_idx == 0)
                            push_beat(8'h00, 1'b1, ST_EMPTY, 7'd0);
                        else
                            for (i = 0; i < int'(wr_idx); i++)
                                push_beat(payload[i], i + 1 == int'(wr_idx), ST_PAYLOAD, wr_idx);
                    end else begin
                        error_cnt++;
                        push_beat(8'h00, 1'b1, ST_CKSUM, wr_idx);
                    end
                end
                default:
                    phase = PH_IDLE;
            endcase
        endfunction

        function string describe(frame_beat_t b);
            return $sformatf("data=%02h last=%0d status=%0d len=%0d frames=%0d errors=%0d lost=%0d",
                             b.data, b.last, b.status, b.frame_length, b.frames, b.errors,
                             b.lost);
        endfunction

        function void check_result(frame_beat_t got);
            frame_beat_t exp;
            checked++;
            if (expected_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result beat: %s", describe(got));
                return;
            end
            exp = expected_beats.pop_front();
            if (got.data !== exp.data || got.last !== exp.last || got.status !== exp.status ||
                got.frame_length !== exp.frame_length || got.frames !== exp.frames ||
                got.errors !== exp.errors || got.lost !== exp.lost) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("mismatch on result beat %0d: got      %s", checked, describe(got));
                    $display("mismatch on result beat %0d: expected %s", checked, describe(exp));
                end
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we;
    logic [1:0]          cfg_index;
    logic [CFG_W-1:0]    cfg_data;
    logic                no_gaps;

    logic [7:0]          cur_start;
    logic [7:0]          cur_end;
    logic [15:0]         cur_timeout;
    int                  beats_sent;
    int                  settings_used;

    frame_scoreboard     sb;

    sfr_in_if  in_ch ();
    sfr_out_if out_ch ();

    serial_frame_receiver u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (in_ch),
        .result    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_ch.ready <= no_gaps || ($urandom_range(0, 99) >= GAP_PCT);
    end

    always @(posedge clk)
    begin : result_monitor
        frame_beat_t got;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            got.data         = out_ch.data;
            got.last         = out_ch.last;
            got.status       = status_t'(out_ch.status);
            got.frame_length = out_ch.frame_length;
            got.frames       = out_ch.frames_seen;
            got.errors       = out_ch.errors_seen;
            got.lost         = out_ch.lost_seen;
            sb.check_result(got);
        end
    end

    // Ends the run if neither channel moves a beat for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic send_beat(input logic kind, input logic [7:0] b);
        while (!no_gaps && $urandom_range(0, 99) < GAP_PCT) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.kind    <= kind;
        in_ch.rx_byte <= b;
        @(posedge clk);
        while (in_ch.ready !== 1'b1)
            @(posedge clk);
        sb.parse_beat(kind, b);
        beats_sent++;
    endtask

    task automatic hold_until_empty();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic drain_and_settle();
        hold_until_empty();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        sb.write_reg(idx, value);
    endtask

    // Upper bits of the 8-bit registers carry junk that must be dropped.
    task automatic apply_settings(input logic [7:0] s, input logic [7:0] e,
                                  input logic [15:0] t);
        write_reg(CFG_START, {8'($urandom), s});
        write_reg(CFG_END, {8'($urandom), e});
        write_reg(CFG_TIMEOUT, t);
        write_reg(CFG_SPARE, 16'($urandom));
        cfg_we <= 1'b0;
        cur_start   = s;
        cur_end     = e;
        cur_timeout = t;
        settings_used++;
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        case ($urandom_range(0, 9))
            0:       b = cur_end;
            1:       b = FILLER_BYTE;
            2:       b = 8'h00;
            3:       b = 8'hFF;
            default: b = 8'($urandom);
        endcase
        if (b == cur_start)
            b = b ^ 8'h01;
        return b;
    endfunction

    // Second byte of an escaped literal pair; anything but the end marker.
    function automatic logic [7:0] pair_byte();
        logic [7:0] x;
        x = ($urandom_range(0, 3) == 0) ? cur_start : 8'($urandom);
        if (x == cur_end)
            x = x ^ 8'h01;
        return x;
    endfunction

    function automatic octet_q_t build_body(input int len, input bit with_pairs);
        octet_q_t q;
        while (q.size() < len) begin
            if (with_pairs && q.size() + 2 <= len && $urandom_range(0, 99) < 12) begin
                q.push_back(cur_start);
                q.push_back(pair_byte());
            end else begin
                q.push_back(plain_byte());
            end
        end
        return q;
    endfunction

    function automatic int frame_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 6);
        if (r < 95)
            return $urandom_range(7, 24);
        return $urandom_range(25, MAX_FRAME);
    endfunction

    // Opening pair plus body, with a stray tick now and then between bytes.
    task automatic send_open(input octet_q_t body);
        send_beat(KIND_BYTE, cur_start);
        send_beat(KIND_BYTE, cur_start);
        foreach (body[i]) begin
            if ($urandom_range(0, 99) < 5)
                send_beat(KIND_TICK, 8'($urandom));
            send_beat(KIND_BYTE, body[i]);
        end
    endtask

    task automatic send_frame(input octet_q_t body, input bit corrupt);
        logic [7:0] sum;
        sum = cur_start ^ cur_end ^ 8'(body.size() + 5);
        foreach (body[i])
            sum ^= body[i];
        if (corrupt)
            sum ^= 8'(1 << $urandom_range(0, 7));
        send_open(body);
        send_beat(KIND_BYTE, cur_start);
        send_beat(KIND_BYTE, cur_end);
        send_beat(KIND_BYTE, sum);
    endtask

    task automatic random_action();
        int pick;
        int n;
        octet_q_t body;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            send_frame(build_body(frame_len(), 1'b1), 1'b0);
        end else if (pick < 63) begin
            send_frame(build_body(frame_len(), 1'b1), 1'b1);
        end else if (pick < 65) begin
            send_open(build_body(MAX_FRAME + 3, 1'b1));
        end else if (pick < 72) begin
            // partial frame left to time out (or linger when the limit is long)
            body = build_body($urandom_range(0, 5), 1'b1);
            if ($urandom_range(0, 1) == 1)
                body.push_back(cur_start);
            send_open(body);
            n = (cur_timeout <= 40) ? int'(cur_timeout) + 1 + $urandom_range(0, 2)
                                    : $urandom_range(1, 4);
            repeat (n) send_beat(KIND_TICK, 8'($urandom));
        end else if (pick < 86) begin
            repeat ($urandom_range(1, 3)) begin
                if ($urandom_range(0, 1) == 1)
                    send_beat(KIND_TICK, 8'($urandom));
                else
                    send_beat(KIND_BYTE, 8'($urandom));
            end
        end else if (pick < 94) begin
            send_beat(KIND_BYTE, cur_start);
            send_beat(KIND_BYTE, plain_byte());
        end else if (pick < 97) begin
            send_beat(KIND_BYTE, FILLER_BYTE);
        end else begin
            hold_until_empty();
        end
    endtask

    task automatic run_setting(input logic [7:0] s, input logic [7:0] e, input logic [15:0] t,
                               input int budget, input bit quiet, input extra_t extra);
        octet_q_t body;
        int goal;
        goal = beats_sent + budget;
        apply_settings(s, e, t);
        no_gaps <= quiet;
        case (extra)
            EXTRA_OVERFLOW:
                send_open(build_body(MAX_FRAME + 1, 1'b0));
            EXTRA_EDGE_OVERFLOW:
            begin
                // one slot left when an escaped pair needs two
                body = build_body(MAX_FRAME - 1, 1'b0);
                body.push_back(cur_start);
                body.push_back(pair_byte());
                send_open(body);
            end
            EXTRA_FULL_FRAME:
                send_frame(build_body(MAX_FRAME, 1'b1), 1'b0);
            default:
                ;
        endcase
        while (beats_sent < goal)
            random_action();
        drain_and_settle();
    endtask

    initial
    begin : stimulus
        octet_q_t body;
        in_ch.valid   <= 1'b0;
        in_ch.kind    <= KIND_BYTE;
        in_ch.rx_byte <= 8'h00;
        cfg_we        <= 1'b0;
        cfg_index     <= CFG_START;
        cfg_data      <= '0;
        no_gaps       <= 1'b0;
        rst_n         <= 1'b0;
        beats_sent    = 0;
        settings_used = 0;
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: strays, filler, tick, single start, empty frame, bad sum, timeout
        apply_settings(START_RST, END_RST, 16'd2);
        send_beat(KIND_BYTE, 8'h00);
        send_beat(KIND_BYTE, 8'hFF);
        send_beat(KIND_BYTE, FILLER_BYTE);
        send_beat(KIND_TICK, 8'hFF);
        send_beat(KIND_BYTE, cur_start);
        send_beat(KIND_BYTE, 8'h55);
        body = {};
        send_frame(body, 1'b0);
        body = {8'hFF};
        send_frame(body, 1'b1);
        send_beat(KIND_BYTE, cur_start);
        send_beat(KIND_BYTE, cur_start);
        send_beat(KIND_BYTE, 8'h07);
        repeat (3) send_beat(KIND_TICK, 8'h00);
        send_beat(KIND_BYTE, 8'h42);
        drain_and_settle();

        run_setting(8'h00, 8'hFF, 16'd1, 35, 1'b0, EXTRA_NONE);
        run_setting(8'hFF, 8'h00, 16'hFFFF, 70, 1'b0, EXTRA_OVERFLOW);
        run_setting(8'h7E, 8'h7D, 16'd3, 70, 1'b1, EXTRA_FULL_FRAME);
        run_setting(8'($urandom), 8'($urandom), 16'($urandom_range(1, 20)), 70, 1'b0,
                    EXTRA_EDGE_OVERFLOW);
        run_setting(8'h55, 8'h55, 16'd6, 30, 1'b0, EXTRA_NONE);
        run_setting(8'hAA, 8'h01, 16'd12, 30, 1'b0, EXTRA_NONE);
        run_setting(START_RST, END_RST, TIMEOUT_RST, 30, 1'b0, EXTRA_NONE);

        $display("Sent %0d input beats under %0d register settings; checked %0d result beats.",
                 beats_sent, settings_used, sb.checked);
        $display("Predicted totals: %0d frames closed, %0d errors, %0d stray bytes.",
                 sb.frame_cnt, sb.error_cnt, sb.lost_cnt);
        if (sb.pending() != 0)
            $display("%0d expected result beats never arrived", sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
